@@ rtl/core/kwl_pkg.sv @@
`timescale 1ns / 1ps
package kwl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_W = 31;
  localparam int SHIFT_W = 8;
  localparam int NAME_W = 64;
  localparam int ENTRY_W = ID_W + SHIFT_W + 2 * NAME_W;
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_PURGE  = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic append;
    logic rd_issue;
    logic check;
    logic finish;
    logic out_take;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic scan_end;
    logic hit_stop;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/core/kwl_ram.sv @@
`timescale 1ns / 1ps
module kwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/kwl_ctrl.sv @@
`timescale 1ns / 1ps
module kwl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_command,
  input  logic            out_ready,
  input  kwl_pkg::sts_t   sts,
  output kwl_pkg::ctl_t   ctl
);

  kwl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    ctl.out_take = out_ready;
    case (state_r)
      kwl_pkg::S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          ctl.capture = 1'b1;
          if (in_command == kwl_pkg::CMD_REMOVE || in_command == kwl_pkg::CMD_PURGE ||
              in_command == kwl_pkg::CMD_LOOKUP) begin
            state_nxt = kwl_pkg::S_READ;
          end else begin
            ctl.append = (in_command == kwl_pkg::CMD_APPEND);
            state_nxt = kwl_pkg::S_DONE;
          end
        end
      end
      kwl_pkg::S_READ: begin
        if (sts.scan_end) begin
          state_nxt = kwl_pkg::S_DONE;
        end else begin
          ctl.rd_issue = 1'b1;
          state_nxt = kwl_pkg::S_CHECK;
        end
      end
      kwl_pkg::S_CHECK: begin
        ctl.check = 1'b1;
        // A lookup stops at its first hit; otherwise the walk goes on.
        if (sts.hit_stop) begin
          state_nxt = kwl_pkg::S_DONE;
        end else begin
          state_nxt = kwl_pkg::S_READ;
        end
      end
      kwl_pkg::S_DONE: begin
        ctl.finish = 1'b1;
        state_nxt = kwl_pkg::S_IDLE;
      end
      default: state_nxt = kwl_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/kwl_dp.sv @@
`timescale 1ns / 1ps
module kwl_dp #(
  parameter int CAPACITY = kwl_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kwl_pkg::ctl_t                 ctl,
  output kwl_pkg::sts_t                 sts,
  input  logic [2:0]                    in_command,
  input  logic [kwl_pkg::ID_W-1:0]      in_student_id,
  input  logic [kwl_pkg::SHIFT_W-1:0]   in_shift_number,
  input  logic [kwl_pkg::NAME_W-1:0]    in_name_low,
  input  logic [kwl_pkg::NAME_W-1:0]    in_name_high,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [kwl_pkg::SHIFT_W-1:0]   out_found_shift,
  output logic [kwl_pkg::NAME_W-1:0]    out_found_name_low,
  output logic [kwl_pkg::NAME_W-1:0]    out_found_name_high,
  output logic [kwl_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = kwl_pkg::ENTRY_W;

  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic          found_r, found_nxt;
  logic [2:0]    cmd_r;
  logic [kwl_pkg::ID_W-1:0]    id_r;
  logic [kwl_pkg::SHIFT_W-1:0] shift_r;
  logic [kwl_pkg::SHIFT_W-1:0] fs_r, fs_nxt;
  logic [kwl_pkg::NAME_W-1:0]  fl_r, fl_nxt, fh_r, fh_nxt;
  logic          full_r, full_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata, rdata;
  logic [kwl_pkg::ID_W-1:0]    e_id;
  logic [kwl_pkg::SHIFT_W-1:0] e_shift;
  logic [kwl_pkg::NAME_W-1:0]  e_lo, e_hi;
  logic          id_hit, keep;

  assign {e_id, e_shift, e_hi, e_lo} = rdata;
  assign id_hit = (e_id == id_r);

  kwl_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rd_r[AW-1:0]), .rdata(rdata)
  );

  assign sts.full     = (occ_r == CW'(CAPACITY));
  assign sts.scan_end = (rd_r >= occ_r);
  assign sts.hit_stop = (cmd_r == kwl_pkg::CMD_LOOKUP) && id_hit;
  assign sts.out_busy = ov_r;

  // An entry survives the walk unless it is the first id hit of a remove
  // or it carries the purged shift.
  always_comb begin
    keep = 1'b1;
    if (cmd_r == kwl_pkg::CMD_REMOVE) begin
      keep = !(id_hit && !found_r);
    end else if (cmd_r == kwl_pkg::CMD_PURGE) begin
      keep = (e_shift != shift_r);
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    found_nxt = found_r;
    fs_nxt = fs_r;
    fl_nxt = fl_r;
    fh_nxt = fh_r;
    full_nxt = full_r;
    ov_nxt = ov_r;
    we = 1'b0;
    waddr = occ_r[AW-1:0];
    wdata = {in_student_id, in_shift_number, in_name_high, in_name_low};
    if (ov_r && ctl.out_take) begin
      ov_nxt = 1'b0;
    end
    if (ctl.capture) begin
      rd_nxt = '0;
      wr_nxt = '0;
      found_nxt = 1'b0;
      fs_nxt = '0;
      fl_nxt = '0;
      fh_nxt = '0;
      full_nxt = 1'b0;
    end
    if (ctl.append) begin
      if (sts.full) begin
        full_nxt = 1'b1;
      end else begin
        we = 1'b1;
        occ_nxt = occ_r + CW'(1);
      end
    end
    if (ctl.rd_issue) begin
      rd_nxt = rd_r + CW'(1);
    end
    if (ctl.check) begin
      if (cmd_r == kwl_pkg::CMD_LOOKUP) begin
        if (id_hit) begin
          found_nxt = 1'b1;
          fs_nxt = e_shift;
          fl_nxt = e_lo;
          fh_nxt = e_hi;
        end
      end else begin
        if (cmd_r == kwl_pkg::CMD_REMOVE && id_hit) begin
          found_nxt = 1'b1;
        end
        if (keep) begin
          we = (wr_r != rd_r - CW'(1));
          waddr = wr_r[AW-1:0];
          wdata = rdata;
          wr_nxt = wr_r + CW'(1);
        end
      end
    end
    if (ctl.finish) begin
      ov_nxt = 1'b1;
      if (cmd_r == kwl_pkg::CMD_REMOVE || cmd_r == kwl_pkg::CMD_PURGE) begin
        occ_nxt = wr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      ov_r  <= ov_nxt;
    end
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    found_r <= found_nxt;
    fs_r <= fs_nxt;
    fl_r <= fl_nxt;
    fh_r <= fh_nxt;
    full_r <= full_nxt;
    if (ctl.capture) begin
      cmd_r <= in_command;
      id_r <= in_student_id;
      shift_r <= in_shift_number;
    end
  end

  assign out_valid = ov_r;
  always_comb begin
    out_status = kwl_pkg::ST_OK;
    if (full_r) begin
      out_status = kwl_pkg::ST_FULL;
    end else if ((cmd_r == kwl_pkg::CMD_REMOVE || cmd_r == kwl_pkg::CMD_LOOKUP) &&
                 !found_r) begin
      out_status = kwl_pkg::ST_MISSING;
    end
  end
  assign out_found_shift = fs_r;
  assign out_found_name_low = fl_r;
  assign out_found_name_high = fh_r;
  assign out_entry_count = kwl_pkg::COUNT_W'(occ_r);

endmodule

@@ rtl/core/keyed_waiting_list_unit.sv @@
`timescale 1ns / 1ps
// Ordered waiting list held in one single-port-write RAM of CAPACITY entries.
// Append, count and unused codes finish without a walk; remove, purge and
// lookup walk the list one entry at a time (registered RAM read, then compare
// and compacting write), a lookup stopping at its first hit. One item is
// worked on at a time; the next is taken once the previous result has been
// delivered.
module keyed_waiting_list_unit #(
  parameter int CAPACITY = kwl_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic [kwl_pkg::ID_W-1:0]      in_student_id,
  input  logic [kwl_pkg::SHIFT_W-1:0]   in_shift_number,
  input  logic [kwl_pkg::NAME_W-1:0]    in_name_low,
  input  logic [kwl_pkg::NAME_W-1:0]    in_name_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [kwl_pkg::SHIFT_W-1:0]   out_found_shift,
  output logic [kwl_pkg::NAME_W-1:0]    out_found_name_low,
  output logic [kwl_pkg::NAME_W-1:0]    out_found_name_high,
  output logic [kwl_pkg::COUNT_W-1:0]   out_entry_count
);

  kwl_pkg::ctl_t ctl;
  kwl_pkg::sts_t sts;

  kwl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .out_ready(out_ready), .sts(sts), .ctl(ctl)
  );

  kwl_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_command(in_command), .in_student_id(in_student_id),
    .in_shift_number(in_shift_number), .in_name_low(in_name_low),
    .in_name_high(in_name_high), .out_valid(out_valid),
    .out_status(out_status), .out_found_shift(out_found_shift),
    .out_found_name_low(out_found_name_low),
    .out_found_name_high(out_found_name_high),
    .out_entry_count(out_entry_count)
  );

endmodule

@@ rtl/core/kwl_checker.sv @@
`timescale 1ns / 1ps
module kwl_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_found_shift
);

  // Only one item is in flight: no new item while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item taken while result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 2'd0) |-> (out_found_shift == 8'd0))
    else $error("found fields set on a miss");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("bad status");

endmodule

bind keyed_waiting_list_unit kwl_assertions u_kwl_assertions (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_found_shift(out_found_shift)
);

@@ tb/kwl_checker.sv @@
`timescale 1ns / 1ps
module kwl_checker
  import kwl_pkg::*;
#(
  parameter int CAP = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic [ID_W-1:0]     in_student_id,
  input  logic [SHIFT_W-1:0]  in_shift_number,
  input  logic [NAME_W-1:0]   in_name_low,
  input  logic [NAME_W-1:0]   in_name_high,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          out_status,
  input  logic [SHIFT_W-1:0]  out_found_shift,
  input  logic [NAME_W-1:0]   out_found_name_low,
  input  logic [NAME_W-1:0]   out_found_name_high,
  input  logic [COUNT_W-1:0]  out_entry_count,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SHIFT_W-1:0] shift;
    logic [NAME_W-1:0]  name_lo;
    logic [NAME_W-1:0]  name_hi;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SHIFT_W-1:0] shift;
    logic [NAME_W-1:0]  name_lo;
    logic [NAME_W-1:0]  name_hi;
    logic [COUNT_W-1:0] count;
  } reply_t;

  entry_t waiting_list[$];
  reply_t expected_replies[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic reply_t apply_command(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                                           input logic [SHIFT_W-1:0] shift,
                                           input logic [NAME_W-1:0] lo,
                                           input logic [NAME_W-1:0] hi);
    reply_t r;
    entry_t e;
    int pos;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    if (cmd == CMD_REMOVE || cmd == CMD_LOOKUP) begin
      foreach (waiting_list[i]) begin
        if (pos < 0 && waiting_list[i].id == id) pos = i;
      end
    end
    case (cmd)
      CMD_APPEND: begin
        if (waiting_list.size() >= CAP) begin
          r.status = ST_FULL;
        end else begin
          e.id = id; e.shift = shift; e.name_lo = lo; e.name_hi = hi;
          waiting_list.push_back(e);
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) r.status = ST_MISSING;
        else waiting_list.delete(pos);
      end
      CMD_PURGE: begin
        for (int i = waiting_list.size() - 1; i >= 0; i--) begin
          if (waiting_list[i].shift == shift) waiting_list.delete(i);
        end
      end
      CMD_LOOKUP: begin
        if (pos < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.shift = waiting_list[pos].shift;
          r.name_lo = waiting_list[pos].name_lo;
          r.name_hi = waiting_list[pos].name_hi;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(waiting_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_status != want.status) report("status", out_status, want.status);
          if (out_found_shift != want.shift) report("found_shift", out_found_shift, want.shift);
          if (out_found_name_low != want.name_lo)
            report("found_name_low", out_found_name_low, want.name_lo);
          if (out_found_name_high != want.name_hi)
            report("found_name_high", out_found_name_high, want.name_hi);
          if (out_entry_count != want.count)
            report("entry_count", out_entry_count, want.count);
        end
      end
      if (in_valid && in_ready) begin
        expected_replies.push_back(apply_command(in_command, in_student_id, in_shift_number,
                                                 in_name_low, in_name_high));
      end
    end
    pending = expected_replies.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import kwl_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_command = '0;
  logic [ID_W-1:0]    in_student_id = '0;
  logic [SHIFT_W-1:0] in_shift_number = '0;
  logic [NAME_W-1:0]  in_name_low = '0;
  logic [NAME_W-1:0]  in_name_high = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [SHIFT_W-1:0] out_found_shift;
  logic [NAME_W-1:0]  out_found_name_low;
  logic [NAME_W-1:0]  out_found_name_high;
  logic [COUNT_W-1:0] out_entry_count;
  int                 fail_count;
  int                 pending;
  bit                 hold_off = 1'b0;

  // Identifiers are mostly drawn from a small pool so that removes and lookups hit.
  logic [ID_W-1:0]    id_pool[8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyed_waiting_list_unit i_dut (.*);

  kwl_checker #(.CAP(CAPACITY_DEF)) i_checker (.*);

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [ID_W-1:0] id,
                           input logic [SHIFT_W-1:0] shift, input logic [NAME_W-1:0] lo,
                           input logic [NAME_W-1:0] hi);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_student_id <= id;
    in_shift_number <= shift;
    in_name_low <= lo;
    in_name_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int bias);
    logic [2:0] cmd;
    int pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    // A fill bias favours appends so the list often reaches capacity.
    if (pick < 40 + bias) cmd = CMD_APPEND;
    else if (pick < 60 + bias / 2) cmd = CMD_REMOVE;
    else if (pick < 68 + bias / 2) cmd = CMD_PURGE;
    else if (pick < 90) cmd = CMD_LOOKUP;
    else if (pick < 95) cmd = CMD_COUNT;
    else cmd = 3'($urandom_range(5, 7));
    id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
    send_item(cmd, id, SHIFT_W'($urandom_range(0, 7)) | ($urandom_range(0, 9) == 0 ?
              SHIFT_W'($urandom) : '0), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic idle_sender();
    int n;
    n = gap_length();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    int n;
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      n = gap_length();
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int guard;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-list misses, extremes, duplicates, unused codes.
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_REMOVE, '1, '0, '0, '0);
    send_item(CMD_PURGE, '0, 8'hff, '0, '0);
    send_item(CMD_APPEND, '0, '0, '0, '0);
    send_item(CMD_APPEND, '1, 8'hff, '1, '1);
    send_item(CMD_APPEND, '1, 8'h5a, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_item(CMD_LOOKUP, '1, '0, '0, '0);
    send_item(CMD_REMOVE, '1, '0, '0, '0);
    send_item(CMD_LOOKUP, '1, '0, '0, '0);
    send_item(CMD_PURGE, '0, 8'h77, '0, '0);
    send_item(CMD_PURGE, '0, 8'h00, '0, '0);
    send_item(CMD_COUNT, '0, '0, '0, '0);
    send_item(3'd5, '1, '1, '1, '1);
    send_item(3'd6, '0, '0, '0, '0);
    send_item(3'd7, '1, '1, '1, '1);
    send_item(CMD_REMOVE, '1, '0, '0, '0);

    // Long receiver hold-off, then appends beyond the list's capacity.
    hold_off = 1'b1;
    fork
      repeat (400) @(negedge clk);
      for (int i = 0; i < CAPACITY_DEF + 3; i++)
        send_item(CMD_APPEND, id_pool[i % 8], SHIFT_W'(i % 5),
                  {$urandom, $urandom}, {$urandom, $urandom});
    join_any
    hold_off = 1'b0;
    wait fork;
    in_valid <= 1'b0;
    send_item(CMD_LOOKUP, id_pool[3], '0, '0, '0);
    send_item(CMD_PURGE, '0, 8'd2, '0, '0);

    // Sender pauses until every expected item has arrived.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 800; i++) begin
      send_random((i / 200) % 2 == 1 ? 30 : 0);
      idle_sender();
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
